[design/svpm_pkg.sv]
// Shared types and constants for the servo position move controller.
// Used by svpm_cfg, svpm_step and servo_position_move_controller; no dependencies.
`default_nettype none

package svpm_pkg;

  localparam int unsigned AngleW   = 12;
  localparam int unsigned SpeedW   = 7;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned TickW    = 8;
  localparam int unsigned DeadW    = 8;
  localparam int unsigned DriveW   = 8;
  localparam int unsigned ElapsedW = 17;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_TARGET_ANGLE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_SPEED      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_MS     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TICK_PERIOD_MS = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DEADBAND       = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_LOCK_DRIVE     = 3'd5;

  // Request codes.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // Register reset values.
  localparam logic [AngleW-1:0]   TargetReset  = 12'd0;
  localparam logic [SpeedW-1:0]   SpeedReset   = 7'd127;
  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd1000;
  localparam logic [TickW-1:0]    TickReset    = 8'd10;
  localparam logic [DeadW-1:0]    DeadReset    = 8'd10;
  localparam logic [DriveW-1:0]   LockReset    = 8'hF6;

  // ceil(2^16 / 5): x*Recip5 >> 16 equals x/5 exactly for x below 16384.
  localparam logic [14:0] Recip5 = 15'd13108;

  typedef enum logic [1:0] {
    EXIT_REACHED   = 2'd0,
    EXIT_TIMEOUT   = 2'd1,
    EXIT_OVERSHOOT = 2'd2
  } exit_reason_e;

  typedef struct packed {
    logic [AngleW-1:0]   target_angle;
    logic [SpeedW-1:0]   max_speed;
    logic [TimeoutW-1:0] timeout_ms;
    logic [TickW-1:0]    tick_period_ms;
    logic [DeadW-1:0]    deadband;
    logic [DriveW-1:0]   lock_drive;
  } cfg_t;

  typedef struct packed {
    logic                moving;
    logic                move_down;
    logic [ElapsedW-1:0] elapsed_ms;
  } move_state_t;

  typedef struct packed {
    logic [DriveW-1:0] motor_drive;
    logic              drive_valid;
    logic              busy_res;
    logic              finished;
    exit_reason_e      exit_reason;
  } result_t;

endpackage

`default_nettype wire

[design/svpm_cfg.sv]
// Configuration register file of the servo position move controller.
// Depends on svpm_pkg.
`default_nettype none

module svpm_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [svpm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [svpm_pkg::CfgDataW-1:0]   cfg_data_i,
  output svpm_pkg::cfg_t                       cfg_o
);

  svpm_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_angle   <= svpm_pkg::TargetReset;
      cfg_q.max_speed      <= svpm_pkg::SpeedReset;
      cfg_q.timeout_ms     <= svpm_pkg::TimeoutReset;
      cfg_q.tick_period_ms <= svpm_pkg::TickReset;
      cfg_q.deadband       <= svpm_pkg::DeadReset;
      cfg_q.lock_drive     <= svpm_pkg::LockReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        svpm_pkg::CFG_TARGET_ANGLE:   cfg_q.target_angle   <= cfg_data_i[svpm_pkg::AngleW-1:0];
        svpm_pkg::CFG_MAX_SPEED:      cfg_q.max_speed      <= cfg_data_i[svpm_pkg::SpeedW-1:0];
        svpm_pkg::CFG_TIMEOUT_MS:     cfg_q.timeout_ms     <= cfg_data_i[svpm_pkg::TimeoutW-1:0];
        svpm_pkg::CFG_TICK_PERIOD_MS: cfg_q.tick_period_ms <= cfg_data_i[svpm_pkg::TickW-1:0];
        svpm_pkg::CFG_DEADBAND:       cfg_q.deadband       <= cfg_data_i[svpm_pkg::DeadW-1:0];
        svpm_pkg::CFG_LOCK_DRIVE:     cfg_q.lock_drive     <= cfg_data_i[svpm_pkg::DriveW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[design/svpm_step.sv]
// Combinational control step: error, deadband, drive scaling and end-of-move tests.
// Depends on svpm_pkg.
`default_nettype none

module svpm_step (
  input  wire svpm_pkg::cfg_t                 cfg_i,
  input  wire svpm_pkg::move_state_t          state_i,
  input  wire logic                           req_type_i,
  input  wire logic [svpm_pkg::AngleW-1:0]    sample_i,
  input  wire logic                           inhibit_i,
  output svpm_pkg::result_t                   result_o,
  output svpm_pkg::move_state_t               state_o
);

  logic                   is_start;
  logic                   do_step;
  logic                   move_down;
  logic [16:0]            elapsed;
  logic signed [12:0]     err;
  logic [12:0]            err_neg;
  logic [11:0]            mag;
  logic                   in_dead;
  logic [13:0]            mag4;
  logic [28:0]            prod;
  logic [11:0]            quot;
  logic [6:0]             drive_mag;
  logic [7:0]             drive;
  logic                   is_timeout;
  logic                   is_over;
  logic                   ends;
  logic [17:0]            elapsed_sum;
  logic [16:0]            elapsed_next;
  svpm_pkg::exit_reason_e reason;

  always_comb begin
    is_start  = (req_type_i == svpm_pkg::REQ_START);
    do_step   = is_start ? !inhibit_i : state_i.moving;
    move_down = is_start ? (sample_i > cfg_i.target_angle) : state_i.move_down;
    elapsed   = is_start ? '0 : state_i.elapsed_ms;

    err     = $signed({1'b0, cfg_i.target_angle}) - $signed({1'b0, sample_i});
    err_neg = 13'(-err);
    mag     = err[12] ? err_neg[11:0] : err[11:0];
    // An exact match counts as zero error even when the deadband is zero.
    in_dead = (mag == 12'd0) || ({1'b0, mag} < {5'b0, cfg_i.deadband});

    // |err|*4/5 by reciprocal multiplication; truncation of the magnitude
    // matches truncation toward zero of the signed quotient.
    mag4      = {mag, 2'b00};
    prod      = {15'b0, mag4} * {14'b0, svpm_pkg::Recip5};
    quot      = prod[27:16];
    drive_mag = (quot > {5'b0, cfg_i.max_speed}) ? cfg_i.max_speed : quot[6:0];
    drive     = err[12] ? 8'(-{1'b0, drive_mag}) : {1'b0, drive_mag};

    is_timeout = (elapsed > {1'b0, cfg_i.timeout_ms});
    is_over    = move_down ? (sample_i < cfg_i.target_angle)
                           : (sample_i > cfg_i.target_angle);
    ends       = in_dead || is_timeout || is_over;

    if (in_dead) begin
      reason = svpm_pkg::EXIT_REACHED;
    end else if (is_timeout) begin
      reason = svpm_pkg::EXIT_TIMEOUT;
    end else begin
      reason = svpm_pkg::EXIT_OVERSHOOT;
    end

    elapsed_sum  = {1'b0, elapsed} + {10'b0, cfg_i.tick_period_ms};
    elapsed_next = elapsed_sum[17] ? '1 : elapsed_sum[16:0];

    result_o.motor_drive = '0;
    result_o.drive_valid = 1'b0;
    result_o.busy_res    = state_i.moving;
    result_o.finished    = 1'b0;
    result_o.exit_reason = svpm_pkg::EXIT_REACHED;
    state_o              = state_i;

    if (do_step) begin
      result_o.drive_valid = 1'b1;
      result_o.busy_res    = !ends;
      state_o.moving       = !ends;
      state_o.move_down    = move_down;
      if (ends) begin
        result_o.motor_drive = cfg_i.lock_drive;
        result_o.finished    = 1'b1;
        result_o.exit_reason = reason;
        state_o.elapsed_ms   = elapsed;
      end else begin
        result_o.motor_drive = drive;
        state_o.elapsed_ms   = elapsed_next;
      end
    end
  end

endmodule

`default_nettype wire

[design/servo_position_move_controller.sv]
// Top level of the servo position move controller: input register, control step,
// result register and move state. Depends on svpm_pkg, svpm_cfg and svpm_step.
//
//   Channel   Direction  Handshake                  Payload
//   in        sink       in_valid_i / in_stall_o    req_type, sensor_angle, start_inhibit
//   out       source     out_valid_o / out_stall_i  motor_drive, drive_valid, busy_res,
//                                                   finished, exit_reason
//   cfg       sink       cfg_we_i                   cfg_idx_i, cfg_data_i
//
// One transaction per cycle while the output is not stalled; an input transaction is held
// in the input register, passes through the step into the result register and is taken
// from there by the output handshake.
// The move state is updated as an item passes from the input register to the
// result register, so consecutive items see each other's effects.
// Reset clears the handshake and move state and loads the register defaults.
// A stall on the output holds the result register and then backs up into the
// input register; in_stall_o rises only when both are full and the output is stalled.
`default_nettype none

module servo_position_move_controller (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [svpm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [svpm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           req_type_i,
  input  wire logic [svpm_pkg::AngleW-1:0]    sensor_angle_i,
  input  wire logic                           start_inhibit_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [svpm_pkg::DriveW-1:0]  motor_drive_o,
  output logic                                drive_valid_o,
  output logic                                busy_res_o,
  output logic                                finished_o,
  output logic [1:0]                          exit_reason_o
);

  svpm_pkg::cfg_t        cfg;
  svpm_pkg::move_state_t state_q;
  svpm_pkg::move_state_t state_d;
  svpm_pkg::result_t     result_d;
  svpm_pkg::result_t     result_q;

  logic                        s1_valid_q;
  logic                        s1_req_q;
  logic [svpm_pkg::AngleW-1:0] s1_sample_q;
  logic                        s1_inhibit_q;
  logic                        out_valid_q;
  logic                        advance;
  logic                        in_accept;

  svpm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  svpm_step u_step (
    .cfg_i      (cfg),
    .state_i    (state_q),
    .req_type_i (s1_req_q),
    .sample_i   (s1_sample_q),
    .inhibit_i  (s1_inhibit_q),
    .result_o   (result_d),
    .state_o    (state_d)
  );

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_req_q     <= req_type_i;
      s1_sample_q  <= sensor_angle_i;
      s1_inhibit_q <= start_inhibit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
      state_q     <= state_d;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign motor_drive_o = result_q.motor_drive;
  assign drive_valid_o = result_q.drive_valid;
  assign busy_res_o    = result_q.busy_res;
  assign finished_o    = result_q.finished;
  assign exit_reason_o = result_q.exit_reason;

endmodule

`default_nettype wire

[dv/tb_servo_position_move_controller.sv]
// Self-checking testbench for servo_position_move_controller: directed moves, then random
// configurations and move sequences with random idling on both sides and a long output stall.
// Depends on svpm_pkg and the controller RTL only.

module tb_servo_position_move_controller;

  localparam int ItemTotal = 1750;
  localparam int AngleMax = 4095;
  localparam int ElapsedMax = 131071;

  // Predicts every result of the controller and holds the results still to come.
  class move_scoreboard;
    logic [svpm_pkg::AngleW-1:0]   target_angle = svpm_pkg::TargetReset;
    logic [svpm_pkg::SpeedW-1:0]   max_speed = svpm_pkg::SpeedReset;
    logic [svpm_pkg::TimeoutW-1:0] timeout_ms = svpm_pkg::TimeoutReset;
    logic [svpm_pkg::TickW-1:0]    tick_period_ms = svpm_pkg::TickReset;
    logic [svpm_pkg::DeadW-1:0]    deadband = svpm_pkg::DeadReset;
    logic [svpm_pkg::DriveW-1:0]   lock_drive = svpm_pkg::LockReset;
    bit                            moving;
    bit                            move_down;
    int                            elapsed_ms;
    svpm_pkg::result_t             result_q[$];
    int                            fail_count;

    function void write_reg(logic [svpm_pkg::CfgIdxW-1:0] idx,
                            logic [svpm_pkg::CfgDataW-1:0] data);
      case (idx)
        svpm_pkg::CFG_TARGET_ANGLE:   target_angle = data[svpm_pkg::AngleW-1:0];
        svpm_pkg::CFG_MAX_SPEED:      max_speed = data[svpm_pkg::SpeedW-1:0];
        svpm_pkg::CFG_TIMEOUT_MS:     timeout_ms = data[svpm_pkg::TimeoutW-1:0];
        svpm_pkg::CFG_TICK_PERIOD_MS: tick_period_ms = data[svpm_pkg::TickW-1:0];
        svpm_pkg::CFG_DEADBAND:       deadband = data[svpm_pkg::DeadW-1:0];
        svpm_pkg::CFG_LOCK_DRIVE:     lock_drive = data[svpm_pkg::DriveW-1:0];
        default: ;
      endcase
    endfunction

    // One proportional step on a sample; ends the move on the first exit condition.
    function svpm_pkg::result_t servo_step(int sample);
      svpm_pkg::result_t      res;
      int                     err;
      int                     mag;
      int                     lim;
      int                     drive;
      int                     total;
      bit                     done;
      svpm_pkg::exit_reason_e why;
      res = '0;
      err = int'(target_angle) - sample;
      mag = (err < 0) ? -err : err;
      lim = int'(max_speed);
      if (mag < int'(deadband)) err = 0;
      drive = (err * 4) / 5;
      if (drive > lim) drive = lim;
      if (drive < -lim) drive = -lim;
      done = 1'b1;
      why = svpm_pkg::EXIT_REACHED;
      if (err == 0) why = svpm_pkg::EXIT_REACHED;
      else if (elapsed_ms > int'(timeout_ms)) why = svpm_pkg::EXIT_TIMEOUT;
      else if (move_down ? (sample < int'(target_angle)) : (sample > int'(target_angle)))
        why = svpm_pkg::EXIT_OVERSHOOT;
      else done = 1'b0;
      if (done) begin
        drive = $signed(lock_drive);
        moving = 1'b0;
        res.exit_reason = why;
      end else begin
        total = elapsed_ms + int'(tick_period_ms);
        elapsed_ms = (total > ElapsedMax) ? ElapsedMax : total;
        res.exit_reason = svpm_pkg::EXIT_REACHED;
      end
      res.motor_drive = drive[svpm_pkg::DriveW-1:0];
      res.drive_valid = 1'b1;
      res.finished = done;
      res.busy_res = moving;
      return res;
    endfunction

    function void note_request(logic req, logic [svpm_pkg::AngleW-1:0] angle, logic inhibit);
      svpm_pkg::result_t res;
      res = '0;
      res.busy_res = moving;
      if (req == svpm_pkg::REQ_START) begin
        if (!inhibit) begin
          elapsed_ms = 0;
          move_down = angle > target_angle;
          moving = 1'b1;
          res = servo_step(int'(angle));
        end
      end else if (moving) begin
        res = servo_step(int'(angle));
      end
      result_q.push_back(res);
    endfunction

    function void check_result(logic [svpm_pkg::DriveW-1:0] drive, logic dv, logic busy,
                               logic fin, logic [1:0] reason);
      svpm_pkg::result_t exp;
      if (result_q.size() == 0) begin
        $error("result transaction with no request pending");
        fail_count++;
        return;
      end
      exp = result_q.pop_front();
      if (drive !== exp.motor_drive) begin
        $error("motor_drive: expected %0d, actual %0d", $signed(exp.motor_drive),
               $signed(drive));
        fail_count++;
      end
      if (dv !== exp.drive_valid) begin
        $error("drive_valid: expected %0b, actual %0b", exp.drive_valid, dv);
        fail_count++;
      end
      if (busy !== exp.busy_res) begin
        $error("busy_res: expected %0b, actual %0b", exp.busy_res, busy);
        fail_count++;
      end
      if (fin !== exp.finished) begin
        $error("finished: expected %0b, actual %0b", exp.finished, fin);
        fail_count++;
      end
      if (reason !== exp.exit_reason) begin
        $error("exit_reason: expected %0d, actual %0d", exp.exit_reason, reason);
        fail_count++;
      end
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [svpm_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [svpm_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic                          req_type_i = svpm_pkg::REQ_TICK;
  logic [svpm_pkg::AngleW-1:0]   sensor_angle_i = '0;
  logic                          start_inhibit_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [svpm_pkg::DriveW-1:0]   motor_drive_o;
  logic                          drive_valid_o;
  logic                          busy_res_o;
  logic                          finished_o;
  logic [1:0]                    exit_reason_o;

  move_scoreboard sb = new();
  int             items_sent;
  int             freeze_cycles;
  bit             send_quiet = 1'b1;
  bit             recv_quiet = 1'b1;

  servo_position_move_controller DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .sensor_angle_i  (sensor_angle_i),
    .start_inhibit_i (start_inhibit_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .motor_drive_o   (motor_drive_o),
    .drive_valid_o   (drive_valid_o),
    .busy_res_o      (busy_res_o),
    .finished_o      (finished_o),
    .exit_reason_o   (exit_reason_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_gap(bit quiet);
    if (quiet) return 0;
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 3);
  endfunction

  // Offers one transaction, waits for it to be taken, then idles for a drawn number of cycles.
  task automatic send_item(logic req, logic [svpm_pkg::AngleW-1:0] angle, logic inhibit);
    int unsigned gap;
    in_valid_i <= 1'b1;
    req_type_i <= req;
    sensor_angle_i <= angle;
    start_inhibit_i <= inhibit;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req, angle, inhibit);
    items_sent++;
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.result_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [svpm_pkg::CfgIdxW-1:0] idx,
                           logic [svpm_pkg::CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic load_config(logic [svpm_pkg::AngleW-1:0] tgt,
                             logic [svpm_pkg::SpeedW-1:0] spd,
                             logic [svpm_pkg::TimeoutW-1:0] tmo,
                             logic [svpm_pkg::TickW-1:0] tick,
                             logic [svpm_pkg::DeadW-1:0] dead,
                             logic [svpm_pkg::DriveW-1:0] lock);
    write_reg(svpm_pkg::CFG_TARGET_ANGLE, svpm_pkg::CfgDataW'(tgt));
    write_reg(svpm_pkg::CFG_MAX_SPEED, svpm_pkg::CfgDataW'(spd));
    write_reg(svpm_pkg::CFG_TIMEOUT_MS, svpm_pkg::CfgDataW'(tmo));
    write_reg(svpm_pkg::CFG_TICK_PERIOD_MS, svpm_pkg::CfgDataW'(tick));
    write_reg(svpm_pkg::CFG_DEADBAND, svpm_pkg::CfgDataW'(dead));
    write_reg(svpm_pkg::CFG_LOCK_DRIVE, svpm_pkg::CfgDataW'(lock));
    cfg_we_i <= 1'b0;
  endtask

  function automatic int pick_angle();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return AngleMax;
    return $urandom_range(0, AngleMax);
  endfunction

  // A crude plant: the shaft mostly closes in on the target, sometimes overshoots or sticks.
  function automatic int next_sample(int pos);
    int tgt;
    int r;
    int k;
    tgt = int'(sb.target_angle);
    r = $urandom_range(0, 99);
    if (r < 55) pos = pos + (tgt - pos) * int'($urandom_range(1, 7)) / 8;
    else if (r < 65) pos = tgt;
    else if (r < 75) begin
      k = $urandom_range(1, 200);
      pos = sb.move_down ? tgt - k : tgt + k;
    end else if (r >= 90) pos = pos + int'($urandom_range(0, 40)) - 20;
    if (pos < 0) pos = 0;
    if (pos > AngleMax) pos = AngleMax;
    return pos;
  endfunction

  task automatic run_move();
    int pos;
    int len;
    pos = pick_angle();
    send_item(svpm_pkg::REQ_START, pos[svpm_pkg::AngleW-1:0], $urandom_range(0, 9) == 0);
    len = $urandom_range(1, 30);
    for (int k = 0; k < len && sb.moving; k++) begin
      pos = next_sample(pos);
      if ($urandom_range(0, 49) == 0)
        send_item(svpm_pkg::REQ_START, pos[svpm_pkg::AngleW-1:0], 1'($urandom_range(0, 1)));
      else
        send_item(svpm_pkg::REQ_TICK, pos[svpm_pkg::AngleW-1:0], 1'($urandom_range(0, 1)));
    end
    repeat ($urandom_range(0, 2))
      send_item(svpm_pkg::REQ_TICK, svpm_pkg::AngleW'($urandom_range(0, AngleMax)),
                1'($urandom_range(0, 1)));
  endtask

  task automatic random_config(int phase);
    int unsigned                   r;
    int                            lk;
    logic [svpm_pkg::AngleW-1:0]   tgt;
    logic [svpm_pkg::SpeedW-1:0]   spd;
    logic [svpm_pkg::TimeoutW-1:0] tmo;
    logic [svpm_pkg::TickW-1:0]    tick;
    logic [svpm_pkg::DeadW-1:0]    dead;
    if (phase == 0) begin
      load_config('0, '0, '0, 8'd1, '0, 8'h81);
      return;
    end
    if (phase == 1) begin
      load_config('1, '1, '1, '1, '1, 8'd127);
      return;
    end
    tgt = svpm_pkg::AngleW'(pick_angle());
    r = $urandom_range(0, 9);
    spd = (r == 0) ? '0 : (r == 1) ? '1 : svpm_pkg::SpeedW'($urandom_range(0, 127));
    r = $urandom_range(0, 9);
    tmo = (r == 0) ? '0 : (r == 1) ? '1 : svpm_pkg::TimeoutW'($urandom_range(0, 600));
    r = $urandom_range(0, 9);
    tick = (r == 0) ? 8'd1 : (r == 1) ? 8'd255 : svpm_pkg::TickW'($urandom_range(1, 255));
    r = $urandom_range(0, 9);
    dead = (r < 2) ? '0 : (r == 2) ? '1 : svpm_pkg::DeadW'($urandom_range(0, 40));
    lk = $urandom_range(0, 254) - 127;
    load_config(tgt, spd, tmo, tick, dead, lk[svpm_pkg::DriveW-1:0]);
  endtask

  initial begin
    int phase;
    int phase_end;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register defaults: target 0, deadband 10, lock drive -10.
    send_item(svpm_pkg::REQ_TICK, 12'd4095, 1'b1);
    send_item(svpm_pkg::REQ_START, 12'd0, 1'b1);
    send_item(svpm_pkg::REQ_START, 12'd0, 1'b0);
    send_item(svpm_pkg::REQ_START, 12'd4095, 1'b0);
    send_item(svpm_pkg::REQ_START, 12'd2000, 1'b1);
    send_item(svpm_pkg::REQ_TICK, 12'd3000, 1'b0);
    send_item(svpm_pkg::REQ_TICK, 12'd5, 1'b0);
    send_item(svpm_pkg::REQ_START, 12'd100, 1'b0);
    send_item(svpm_pkg::REQ_TICK, 12'd200, 1'b1);
    send_item(svpm_pkg::REQ_TICK, 12'd0, 1'b0);
    settle();

    // No deadband and a short timeout: exact arrival, overshoot both ways, timeout, restart.
    load_config(12'd2048, 7'd127, 16'd30, 8'd10, 8'd0, 8'd127);
    send_item(svpm_pkg::REQ_START, 12'd2048, 1'b0);
    send_item(svpm_pkg::REQ_START, 12'd2049, 1'b0);
    send_item(svpm_pkg::REQ_TICK, 12'd2047, 1'b0);
    send_item(svpm_pkg::REQ_START, 12'd0, 1'b0);
    repeat (4) send_item(svpm_pkg::REQ_TICK, 12'd1000, 1'b0);
    send_item(svpm_pkg::REQ_START, 12'd4095, 1'b1);
    send_item(svpm_pkg::REQ_START, 12'd4095, 1'b0);
    send_item(svpm_pkg::REQ_START, 12'd0, 1'b0);
    send_item(svpm_pkg::REQ_TICK, 12'd2100, 1'b0);

    phase = 0;
    while (items_sent < ItemTotal) begin
      settle();
      random_config(phase);
      send_quiet = $urandom_range(0, 3) == 0;
      recv_quiet = $urandom_range(0, 3) == 0;
      if (phase == 1) begin
        // Longest timeout at the longest tick: a stuck shaft runs until the timer expires.
        send_item(svpm_pkg::REQ_START, 12'd3000, 1'b0);
        while (sb.moving) send_item(svpm_pkg::REQ_TICK, 12'd3000, 1'b0);
      end
      if (phase == 3) begin
        send_quiet = 1'b1;
        freeze_cycles = 150;
      end
      phase_end = items_sent + 60;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 4) != 0)
          run_move();
        else
          send_item(1'($urandom_range(0, 1)),
                    svpm_pkg::AngleW'($urandom_range(0, AngleMax)),
                    1'($urandom_range(0, 1)));
      end
      phase++;
    end
    settle();
    repeat (8) @(posedge clk_i);
    if (sb.result_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.result_q.size());
      sb.fail_count++;
    end
    if (sb.fail_count == 0) begin
      $display("servo_position_move_controller: match");
    end else begin
      $display("servo_position_move_controller: mismatch");
    end
    $finish;
  end

  // Result side: takes each result transaction, then holds off for a drawn number of cycles.
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (out_valid_o && !out_stall_i) begin
          sb.check_result(motor_drive_o, drive_valid_o, busy_res_o, finished_o, exit_reason_o);
          hold = draw_gap(recv_quiet);
        end else if (hold > 0) begin
          hold--;
        end
        if (freeze_cycles > 0) freeze_cycles--;
        out_stall_i <= (hold > 0) || (freeze_cycles > 0);
      end
    end
  end

  initial begin
    #40_000_000;
    $display("servo_position_move_controller: mismatch");
    $finish;
  end

endmodule

[sim.f]
design/svpm_pkg.sv
design/svpm_cfg.sv
design/svpm_step.sv
design/servo_position_move_controller.sv
dv/tb_servo_position_move_controller.sv
